### rtl/garz_pkg.sv
// ----------------------------------------------------------------------------
// garz_pkg: shared types and constants of the gray area/nearest resizer
// transaction structs, controller/datapath command and status groups
// ----------------------------------------------------------------------------
package garz_pkg;

  localparam int unsigned CfgW = 9;
  localparam int unsigned CoordW = 8;
  localparam int unsigned PixW = 8;
  localparam int unsigned SumW = 24;
  localparam int unsigned DivW = 16;

  localparam logic [1:0] RegSrcW = 2'd0;
  localparam logic [1:0] RegSrcH = 2'd1;
  localparam logic [1:0] RegDstW = 2'd2;
  localparam logic [1:0] RegDstH = 2'd3;

  localparam logic [PixW-1:0] EmptyBoxGray = 8'd255;

  typedef struct packed {
    logic       mode;
    logic [7:0] src_col;
    logic [7:0] src_row;
    logic [7:0] src_pixel;
    logic [7:0] dst_col;
    logic [7:0] dst_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       bad_request;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item, start bound division
    logic div_step;  // one bit of the bound dividers
    logic bounds;    // finish bounds
    logic acc_first; // issue first box read
    logic acc_step;  // accumulate and advance the box walk
    logic mean_step; // one bit of mean division
    logic finish;    // register result
  } garz_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic bad;
    logic store_ok;
    logic div_done;
    logic box_last;
    logic mean_done;
  } garz_sts_t;

endpackage

### rtl/garz_ctrl.sv
// ----------------------------------------------------------------------------
// garz_ctrl: sequencer of the resizer
// walks load, then either a store write or bound division, box accumulation, mean division and output
// ----------------------------------------------------------------------------
module garz_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  garz_pkg::garz_sts_t sts,
  output garz_pkg::garz_cmd_t cmd,
  output logic                wr_en
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DECO  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_BND   = 8'b0000_1000,
    ST_FIRST = 8'b0001_0000,
    ST_ACC   = 8'b0010_0000,
    ST_MEAN  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  // a new item may enter while the last result waits; a query waits at ST_FIN
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    wr_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECO;
        end
      end
      ST_DECO: begin
        if (!sts.is_query) begin
          wr_en     = sts.store_ok;
          state_nxt = ST_IDLE;
        end else if (sts.bad) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_BND;
      end
      ST_BND: begin
        cmd.bounds = 1'b1;
        state_nxt  = ST_FIRST;
      end
      ST_FIRST: begin
        cmd.acc_first = 1'b1;
        state_nxt     = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.box_last) state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.mean_step = 1'b1;
        if (sts.mean_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/garz_dp.sv
// ----------------------------------------------------------------------------
// garz_dp: resizer datapath
// frame store, bound dividers, box walk, accumulator, mean divider
// ----------------------------------------------------------------------------
module garz_dp #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  garz_pkg::in_item_t  in_data,
  input  logic [8:0]          sw,
  input  logic [8:0]          sh,
  input  logic [8:0]          dw,
  input  logic [8:0]          dh,
  input  garz_pkg::garz_cmd_t cmd,
  input  logic                wr_en,
  output garz_pkg::garz_sts_t sts,
  output garz_pkg::out_item_t out_data
);

  // effective sizes never exceed 256, so 8 address bits per axis suffice
  localparam int unsigned ColW  = (MAX_WIDTH  >= 256) ? 8 :
                                  ((MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1);
  localparam int unsigned RowW  = (MAX_HEIGHT >= 256) ? 8 :
                                  ((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1);
  localparam int unsigned AddrW = ColW + RowW;
  localparam int unsigned Depth = 2 ** AddrW;
  localparam int unsigned DivW  = garz_pkg::DivW;
  localparam int unsigned SumW  = garz_pkg::SumW;
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned CntW  = 5;

  logic [garz_pkg::PixW-1:0] mem [Depth];

  garz_pkg::in_item_t item_r;
  // four bound dividers: x lo, x hi, y lo, y hi
  logic [DivW-1:0] num_r [4];
  logic [DivW-1:0] rem_r [4];
  logic [DivW-1:0] quo_r [4];
  logic [8:0]      den_r [4];
  logic [CntW-1:0] cnt_r;
  logic            area_r;
  logic [8:0] x0_r, x1_r, y1_r, x_r, y_r;
  logic [SumW-1:0] sum_r, msum_r, mrem_r, mquo_r;
  logic [16:0]     count_r;
  logic [SumW-1:0] mcnt_r;
  logic [garz_pkg::PixW-1:0] rd_r;
  garz_pkg::out_item_t res_r;

  logic [8:0] dc9, dr9;
  assign dc9 = {1'b0, item_r.dst_col};
  assign dr9 = {1'b0, item_r.dst_row};

  assign sts.is_query  = item_r.mode;
  assign sts.bad       = (dc9 >= dw) || (dr9 >= dh);
  assign sts.store_ok  = ({1'b0, item_r.src_col} < sw) && ({1'b0, item_r.src_row} < sh);
  assign sts.div_done  = (cnt_r == CntW'(DivSteps - 1));
  assign sts.box_last  = !area_r || ((x_r + 9'd1 >= x1_r) && (y_r + 9'd1 >= y1_r));
  assign sts.mean_done = (cnt_r == CntW'(SumW - 1));
  assign out_data      = res_r;

  function automatic logic [AddrW-1:0] addr_of(input logic [8:0] c, input logic [8:0] r);
    addr_of = {r[RowW-1:0], c[ColW-1:0]};
  endfunction

  // next box position; the read runs one pixel ahead of the accumulator
  logic [8:0] nx, ny;
  logic [AddrW-1:0] rd_addr;
  always_comb begin
    nx = x_r + 9'd1;
    ny = y_r;
    if (x_r + 9'd1 >= x1_r) begin
      nx = x0_r;
      ny = y_r + 9'd1;
    end
    rd_addr = addr_of(x_r, y_r);
    if (cmd.acc_step) rd_addr = addr_of(nx, ny);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_of({1'b0, item_r.src_col}, {1'b0, item_r.src_row})] <= item_r.src_pixel;
    rd_r <= mem[rd_addr];
  end

  // restoring divider step
  function automatic logic [2*DivW:0] dstep(input logic [DivW-1:0] rem,
                                            input logic [DivW-1:0] num,
                                            input logic [DivW-1:0] quo,
                                            input logic [8:0] den);
    logic [DivW:0] t;
    t = {rem, num[DivW-1]};
    if (t >= {{(DivW-8){1'b0}}, den}) begin
      dstep = {t[DivW-1:0] - {{(DivW-9){1'b0}}, den}, {quo[DivW-2:0], 1'b1}, 1'b0};
    end else begin
      dstep = {t[DivW-1:0], {quo[DivW-2:0], 1'b0}, 1'b0};
    end
  endfunction

  logic [2*DivW:0] dres [4];
  always_comb begin
    for (int i = 0; i < 4; i++) dres[i] = dstep(rem_r[i], num_r[i], quo_r[i], den_r[i]);
  end

  logic [8:0] a_x, a_y, b_x, b_y, sm1w, sm1h;
  always_comb begin
    sm1w = sw - 9'd1;
    sm1h = sh - 9'd1;
    a_x  = quo_r[0][8:0];
    a_y  = quo_r[2][8:0];
    b_x  = quo_r[1][8:0];
    b_y  = quo_r[3][8:0];
    if (b_x < a_x + 9'd1) b_x = a_x + 9'd1;
    if (b_x > sw) b_x = sw;
    if (b_y < a_y + 9'd1) b_y = a_y + 9'd1;
    if (b_y > sh) b_y = sh;
    if (!area_r) begin
      if (a_x > sm1w) a_x = sm1w;
      if (a_y > sm1h) a_y = sm1h;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= sts.div_done ? '0 : cnt_r + CntW'(1);
    end else if (cmd.mean_step) begin
      cnt_r <= sts.mean_done ? '0 : cnt_r + CntW'(1);
    end else begin
      cnt_r <= '0;
    end
    if (!cmd.div_step && !cmd.bounds) begin
      // setup: numerators d*S and (d+1)*S+T-1
      area_r   <= !((dw >= sw) || (dh >= sh));
      num_r[0] <= DivW'(dc9) * DivW'(sw);
      num_r[1] <= (DivW'(dc9) + DivW'(1)) * DivW'(sw) + DivW'(dw) - DivW'(1);
      num_r[2] <= DivW'(dr9) * DivW'(sh);
      num_r[3] <= (DivW'(dr9) + DivW'(1)) * DivW'(sh) + DivW'(dh) - DivW'(1);
      den_r[0] <= dw; den_r[1] <= dw; den_r[2] <= dh; den_r[3] <= dh;
      for (int i = 0; i < 4; i++) begin
        rem_r[i] <= '0;
        quo_r[i] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 4; i++) begin
        rem_r[i] <= dres[i][2*DivW:DivW+1];
        quo_r[i] <= dres[i][DivW:1];
        num_r[i] <= num_r[i] << 1;
      end
    end
    if (cmd.bounds) begin
      x0_r <= a_x; x_r <= a_x; x1_r <= b_x;
      y_r  <= a_y; y1_r <= b_y;
      sum_r   <= '0;
      count_r <= '0;
    end
    if (cmd.acc_step) begin
      sum_r   <= sum_r + SumW'(rd_r);
      count_r <= count_r + 17'd1;
      x_r     <= nx;
      y_r     <= ny;
    end
    if (cmd.acc_step && sts.box_last) begin
      msum_r <= sum_r + SumW'(rd_r);
      mcnt_r <= SumW'(count_r + 17'd1);
      mrem_r <= '0;
      mquo_r <= '0;
    end else if (cmd.mean_step) begin
      msum_r <= msum_r << 1;
      if ({mrem_r[SumW-2:0], msum_r[SumW-1]} >= mcnt_r) begin
        mrem_r <= {mrem_r[SumW-2:0], msum_r[SumW-1]} - mcnt_r;
        mquo_r <= {mquo_r[SumW-2:0], 1'b1};
      end else begin
        mrem_r <= {mrem_r[SumW-2:0], msum_r[SumW-1]};
        mquo_r <= {mquo_r[SumW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      if (sts.bad) begin
        res_r.gray        <= '0;
        res_r.bad_request <= 1'b1;
      end else begin
        res_r.gray        <= (mcnt_r == '0) ? garz_pkg::EmptyBoxGray
                             : garz_pkg::PixW'(mquo_r);
        res_r.bad_request <= 1'b0;
      end
    end
  end

endmodule

### rtl/gray_area_nearest_resize_unit.sv
// ----------------------------------------------------------------------------
// gray_area_nearest_resize_unit: grayscale box-average / nearest resizer
// store transactions write the frame store, query transactions return a pixel
// ----------------------------------------------------------------------------
// store: no result
// query: decode, bound division, bounds, first box read, box accumulation (one store read a cycle),
//   mean division and result; nearest mode has a box of one pixel
// one transaction at a time; a finished result waits in the output register
// reset: registers return to 256/256/128/128, frame store is not cleared
module gray_area_nearest_resize_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  garz_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output garz_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data
);

  localparam logic [8:0] LimW = (MAX_WIDTH  < 256) ? 9'(MAX_WIDTH)  : 9'd256;
  localparam logic [8:0] LimH = (MAX_HEIGHT < 256) ? 9'(MAX_HEIGHT) : 9'd256;

  logic [8:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [8:0] sw, sh, dw, dh;
  garz_pkg::garz_cmd_t cmd;
  garz_pkg::garz_sts_t sts;
  logic wr_en;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256;
      src_h_r <= 9'd256;
      dst_w_r <= 9'd128;
      dst_h_r <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        garz_pkg::RegSrcW: src_w_r <= cfg_data;
        garz_pkg::RegSrcH: src_h_r <= cfg_data;
        garz_pkg::RegDstW: dst_w_r <= cfg_data;
        garz_pkg::RegDstH: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, large values clamp to the limit
  function automatic logic [8:0] eff(input logic [8:0] v, input logic [8:0] lim);
    if (v == 9'd0) eff = 9'd1;
    else if (v > lim) eff = lim;
    else eff = v;
  endfunction

  assign sw = eff(src_w_r, LimW);
  assign sh = eff(src_h_r, LimH);
  assign dw = eff(dst_w_r, 9'd256);
  assign dh = eff(dst_h_r, 9'd256);

  garz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .wr_en     (wr_en)
  );

  garz_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .sw       (sw),
    .sh       (sh),
    .dw       (dw),
    .dh       (dh),
    .cmd      (cmd),
    .wr_en    (wr_en),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### dv/gray_area_nearest_resize_unit_test.sv
// ----------------------------------------------------------------------------
// gray_area_nearest_resize_unit_test: self-checking bench of the gray resizer
// random store/query transactions over several size settings, results checked
// in order against a frame store and resize predictor kept in the bench
// ----------------------------------------------------------------------------
module gray_area_nearest_resize_unit_test;

  localparam int unsigned CycleLimit = 3000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  garz_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  garz_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = garz_pkg::RegSrcW;
  logic [8:0]          cfg_data = '0;

  always #4 clk = ~clk;

  gray_area_nearest_resize_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicts resized pixels and holds the results still owed by the block
  class resize_scoreboard;
    logic [7:0]          pixels [65536];
    logic [8:0]          regs [4];
    garz_pkg::out_item_t owed [$];
    int unsigned         errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      regs[garz_pkg::RegSrcW] = 9'd256;
      regs[garz_pkg::RegSrcH] = 9'd256;
      regs[garz_pkg::RegDstW] = 9'd128;
      regs[garz_pkg::RegDstH] = 9'd128;
      errors = 0;
    endfunction

    // zero acts as one, anything past 256 saturates
    function int unsigned dim(logic [1:0] idx);
      if (regs[idx] == 0) return 1;
      if (regs[idx] > 256) return 256;
      return regs[idx];
    endfunction

    function void span(int unsigned d, int unsigned s, int unsigned t,
                       output int unsigned lo, output int unsigned hi);
      lo = (d * s) / t;
      hi = ((d + 1) * s + t - 1) / t;
      if (hi < lo + 1) hi = lo + 1;
      if (hi > s) hi = s;
    endfunction

    function bit outside(int unsigned dc, int unsigned dr);
      return dc >= dim(garz_pkg::RegDstW) || dr >= dim(garz_pkg::RegDstH);
    endfunction

    // source box read for a target pixel, half-open in both directions
    function void region(int unsigned dc, int unsigned dr,
                         output int unsigned x0, output int unsigned x1,
                         output int unsigned y0, output int unsigned y1);
      int unsigned sw, sh, dw, dh;
      sw = dim(garz_pkg::RegSrcW);
      sh = dim(garz_pkg::RegSrcH);
      dw = dim(garz_pkg::RegDstW);
      dh = dim(garz_pkg::RegDstH);
      if (dw >= sw || dh >= sh) begin
        // nearest neighbour
        x0 = (dc * sw) / dw;
        y0 = (dr * sh) / dh;
        if (x0 > sw - 1) x0 = sw - 1;
        if (y0 > sh - 1) y0 = sh - 1;
        x1 = x0 + 1;
        y1 = y0 + 1;
      end else begin
        span(dc, sw, dw, x0, x1);
        span(dr, sh, dh, y0, y1);
      end
    endfunction

    function void note_input(garz_pkg::in_item_t it);
      int unsigned x0, x1, y0, y1, sum, cnt;
      garz_pkg::out_item_t r;
      if (!it.mode) begin
        if (it.src_col < dim(garz_pkg::RegSrcW) && it.src_row < dim(garz_pkg::RegSrcH))
          pixels[{it.src_row, it.src_col}] = it.src_pixel;
        return;
      end
      if (outside(it.dst_col, it.dst_row)) begin
        r.gray = '0;
        r.bad_request = 1'b1;
      end else begin
        region(it.dst_col, it.dst_row, x0, x1, y0, y1);
        sum = 0;
        cnt = 0;
        for (int unsigned y = y0; y < y1; y++)
          for (int unsigned x = x0; x < x1; x++) begin
            sum += pixels[y * 256 + x];
            cnt++;
          end
        r.gray = (cnt == 0) ? garz_pkg::EmptyBoxGray : 8'(sum / cnt);
        r.bad_request = 1'b0;
      end
      owed.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("result error: %s got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check(garz_pkg::out_item_t r);
      garz_pkg::out_item_t w;
      if (owed.size() == 0) begin
        report("unexpected transaction, gray", r.gray, 0);
        return;
      end
      w = owed.pop_front();
      if (r.gray !== w.gray) report("gray", r.gray, w.gray);
      if (r.bad_request !== w.bad_request)
        report("bad_request", r.bad_request, w.bad_request);
    endtask
  endclass

  resize_scoreboard sb = new();

  bit          written [65536];  // source pixels stored at least once
  int unsigned burst_left = 0;
  int unsigned sent = 0;         // accepted input transactions
  bit          long_hold = 1'b0; // request for one long receiver stall
  int unsigned cycles = 0;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("gray_area_nearest_resize_unit: mismatch");
      $finish;
    end
  end

  // result monitor, samples at the edge where the transaction completes
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  // receiver: stall style is redrawn periodically, plus a long hold whenever one is requested
  int unsigned hold_cnt = 0;
  int unsigned rx_style = 0;
  always @(posedge clk) begin
    if (cycles % 300 == 0) rx_style <= $urandom_range(0, 3);
    if (long_hold && hold_cnt == 0) begin
      hold_cnt <= 400;
      long_hold <= 1'b0;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else begin
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= (cycles % 4 != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // offer one transaction, honoring the burst/gap pattern of the sender
  task send(garz_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent++;
    burst_left--;
  endtask

  task store_px(int unsigned col, int unsigned row, logic [7:0] px);
    garz_pkg::in_item_t it;
    it = '0;
    it.mode = 1'b0;
    it.src_col = 8'(col);
    it.src_row = 8'(row);
    it.src_pixel = px;
    it.dst_col = 8'($urandom_range(0, 255));
    it.dst_row = 8'($urandom_range(0, 255));
    send(it);
    if (col < sb.dim(garz_pkg::RegSrcW) && row < sb.dim(garz_pkg::RegSrcH))
      written[row * 256 + col] = 1'b1;
  endtask

  // query; any pixel of its box never written is stored first
  task query_px(int unsigned dc, int unsigned dr);
    int unsigned x0, x1, y0, y1;
    garz_pkg::in_item_t it;
    if (!sb.outside(dc, dr)) begin
      sb.region(dc, dr, x0, x1, y0, y1);
      for (int unsigned y = y0; y < y1; y++)
        for (int unsigned x = x0; x < x1; x++)
          if (!written[y * 256 + x]) store_px(x, y, 8'($urandom_range(0, 255)));
    end
    it = '0;
    it.mode = 1'b1;
    it.src_col = 8'($urandom_range(0, 255));
    it.src_row = 8'($urandom_range(0, 255));
    it.src_pixel = 8'($urandom_range(0, 255));
    it.dst_col = 8'(dc);
    it.dst_row = 8'(dr);
    send(it);
  endtask

  // registers change only with the block idle
  task set_sizes(logic [8:0] sw, logic [8:0] sh, logic [8:0] dw, logic [8:0] dh);
    logic [8:0] vals [4];
    vals = '{sw, sh, dw, dh};
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);  // a trailing store may still be in flight
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      sb.regs[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // runs until n more transactions were accepted, box fills included
  task random_phase(int unsigned n, bit pressure);
    int unsigned sw, sh, dw, dh, stop, mid;
    bit held;
    stop = sent + n;
    mid = sent + n / 2;
    held = 1'b0;
    while (sent < stop) begin
      sw = sb.dim(garz_pkg::RegSrcW);
      sh = sb.dim(garz_pkg::RegSrcH);
      dw = sb.dim(garz_pkg::RegDstW);
      dh = sb.dim(garz_pkg::RegDstH);
      if (pressure && !held && sent >= mid) begin
        long_hold = 1'b1;
        held = 1'b1;
      end
      if ($urandom_range(0, 9) < 5) begin
        if ($urandom_range(0, 9) == 0)
          query_px($urandom_range(0, 255), $urandom_range(0, 255));
        else
          query_px($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
      end else if ($urandom_range(0, 9) == 0) begin
        store_px($urandom_range(0, 255), $urandom_range(0, 255),
                 8'($urandom_range(0, 255)));
      end else begin
        store_px($urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // oversized values only where they keep the boxes small
  function logic [8:0] rand_dim(bit big);
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return big ? 9'($urandom_range(257, 511)) : 9'($urandom_range(1, 24));
      default: return 9'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    foreach (written[i]) written[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default sizes, corner pixels, out-of-range query
    store_px(255, 255, 8'hff);
    store_px(254, 255, 8'h00);
    store_px(255, 254, 8'h80);
    store_px(254, 254, 8'h01);
    query_px(127, 127);
    query_px(0, 0);
    query_px(128, 5);
    query_px(3, 255);
    // zero registers act as one
    set_sizes(9'd0, 9'd0, 9'd0, 9'd0);
    store_px(0, 0, 8'h5a);
    store_px(1, 0, 8'h11);  // outside the source, dropped
    query_px(0, 0);
    query_px(1, 0);
    // oversized registers saturate, nearest at full size
    set_sizes(9'd511, 9'd300, 9'd511, 9'd256);
    query_px(255, 255);
    query_px(0, 255);
    // area downscale with uneven boxes
    set_sizes(9'd23, 9'd17, 9'd7, 9'd5);
    query_px(6, 4);
    query_px(3, 2);
    store_px(22, 16, 8'hff);
    query_px(6, 4);
    query_px(7, 0);
    // one dimension grows, so nearest for both
    set_sizes(9'd9, 9'd20, 9'd16, 9'd3);
    query_px(15, 2);
    query_px(8, 1);

    // random part over several size settings, two with a long output hold
    set_sizes(9'd256, 9'd256, 9'd128, 9'd128);
    random_phase(60, 1'b1);
    for (int p = 0; p < 9; p++) begin
      set_sizes(rand_dim(1'b0), rand_dim(1'b0), rand_dim(1'b1), rand_dim(1'b1));
      random_phase(60, p == 4);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("gray_area_nearest_resize_unit: match");
    end else begin
      $display("gray_area_nearest_resize_unit: mismatch");
    end
    $finish;
  end

endmodule
